@@ src/locally_connected_1d_layer_unit_assert.svh @@
// Assertion macros for the locally connected 1D layer unit.
`ifndef LOCALLY_CONNECTED_1D_LAYER_UNIT_ASSERT_SVH
`define LOCALLY_CONNECTED_1D_LAYER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define LC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ src/lc1d_pkg.sv @@
// Package with constants, types and helpers for the locally connected 1D layer unit.
`timescale 1ns / 1ps
package lc1d_pkg;
   localparam int CHANNELS  = 4;
   localparam int KERNEL    = 3;
   localparam int FILTERS   = 8;
   localparam int POSITIONS = 64;
   localparam int WIN_LEN   = KERNEL * CHANNELS;
   localparam int W_DEPTH   = POSITIONS * FILTERS * WIN_LEN;
   localparam int B_DEPTH   = POSITIONS * FILTERS;
   localparam int WIN_W     = $clog2(WIN_LEN);
   localparam int WA_W      = $clog2(W_DEPTH);
   localparam int BA_W      = $clog2(B_DEPTH);
   localparam int ACC_W     = 40;

   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_BIAS   = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   localparam logic [1:0] CSR_POSITIONS = 2'd0;
   localparam logic [1:0] CSR_FILTERS   = 2'd1;
   localparam logic [1:0] CSR_TAPS      = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_MAC, ST_DONE, ST_OUT
   } state_type;

   // Control handed from the sequencer to the cell row.
   typedef struct packed {
      logic clear;   // zero the window
      logic shift;   // shift a sample in
      logic rotate;  // rotate the window by one cell
   } win_ctl_type;
endpackage

@@ src/lc1d_cell.sv @@
// One window cell: holds a sample and passes it to its neighbor.
`timescale 1ns / 1ps
module lc1d_cell (
   input  logic                clock,
   input  logic                reset,
   input  lc1d_pkg::win_ctl_type ctl,
   input  logic signed [15:0]  from_next,
   output logic signed [15:0]  data
);
   import lc1d_pkg::*;
   logic signed [15:0] data_ff, data_in;
   always_comb begin
      data_in = data_ff;
      if (ctl.clear) data_in = '0;
      else if (ctl.shift || ctl.rotate) data_in = from_next;
   end
   always_ff @(posedge clock) begin
      if (reset) data_ff <= '0;
      else data_ff <= data_in;
   end
   assign data = data_ff;
endmodule

@@ src/lc1d_window.sv @@
// Row of window cells; cell 0 is oldest, new samples enter at the top.
`timescale 1ns / 1ps
module lc1d_window (
   input  logic                  clock,
   input  logic                  reset,
   input  lc1d_pkg::win_ctl_type ctl,
   input  logic signed [15:0]    sample,
   input  logic [lc1d_pkg::WIN_W-1:0] head,
   output logic signed [15:0]    tap_out
);
   import lc1d_pkg::*;
   logic signed [15:0] cell_q [WIN_LEN];
   // Rotation feeds cell 0 back into the cell at head, so the active part
   // of the window cycles past cell 0 one element per cycle.
   for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
      logic signed [15:0] nxt;
      win_ctl_type c;
      always_comb begin
         c = ctl;
         if (ctl.rotate && (WIN_W'(i) > head)) c.rotate = 1'b0;
         // A sample that starts a sequence lands in the top cell while the
         // rest of the row is cleared.
         if (ctl.clear && ctl.shift && (i == WIN_LEN - 1)) c.clear = 1'b0;
         if (ctl.shift) nxt = (i == WIN_LEN - 1) ? sample : cell_q[(i + 1) % WIN_LEN];
         else if (WIN_W'(i) == head) nxt = cell_q[0];
         else nxt = cell_q[(i + 1) % WIN_LEN];
      end
      lc1d_cell u_cell (.clock, .reset, .ctl(c), .from_next(nxt), .data(cell_q[i]));
   end
   assign tap_out = cell_q[0];
endmodule

@@ src/locally_connected_1d_layer_unit.sv @@
// Top level of the locally connected 1D layer unit.
`timescale 1ns / 1ps
// Channel   Direction  Signals
// req       in         req_valid/req_ready, opcode position filter tap value first
// rsp       out        rsp_valid/rsp_ready, out_position out_filter result saturated last
// csr       in         csr_write/csr_index/csr_data, no wait
// Loads and samples that complete no window are taken in the idle state. A completing
// sample is followed, per filter in use, by a bias fetch, a MAC phase (the whole
// window rotates past the single multiplier; cells outside taps_used add zero),
// a pipeline drain and an output state that waits for rsp_ready.
// Reset is synchronous and clears control state, the settings and the window.
// A stalled result holds the sequencer; the input stays not ready meanwhile.
module locally_connected_1d_layer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_position,
   input  logic [2:0]  req_filter,
   input  logic [3:0]  req_tap,
   input  logic signed [15:0] req_value,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_out_position,
   output logic [2:0]  rsp_out_filter,
   output logic signed [15:0] rsp_result,
   output logic        rsp_saturated,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import lc1d_pkg::*;
`include "locally_connected_1d_layer_unit_assert.svh"

   // Configuration registers, clamped to their legal ranges at use.
   logic [6:0] pos_cfg_ff;
   logic [3:0] fil_cfg_ff;
   logic [1:0] tap_cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_cfg_ff <= 7'd64; fil_cfg_ff <= 4'd8; tap_cfg_ff <= 2'd3;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POSITIONS: pos_cfg_ff <= csr_data;
            CSR_FILTERS:   fil_cfg_ff <= csr_data[3:0];
            CSR_TAPS:      tap_cfg_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end
   logic [6:0] pu;
   logic [3:0] fu;
   logic [1:0] tu;
   logic [WIN_W-1:0] wl;
   always_comb begin
      pu = (pos_cfg_ff == 0) ? 7'd1 : (pos_cfg_ff > 7'(POSITIONS) ? 7'(POSITIONS) : pos_cfg_ff);
      fu = (fil_cfg_ff == 0) ? 4'd1 : (fil_cfg_ff > 4'(FILTERS) ? 4'(FILTERS) : fil_cfg_ff);
      tu = (tap_cfg_ff == 0) ? 2'd1 : (tap_cfg_ff > 2'(KERNEL) ? 2'(KERNEL) : tap_cfg_ff);
      wl = WIN_W'(tu * CHANNELS);
   end

   // Weight and bias memories, one write and one registered read each.
   logic signed [15:0] wmem [W_DEPTH];
   logic signed [15:0] bmem [B_DEPTH];
   logic signed [15:0] wrd_ff, brd_ff;
   logic [WA_W-1:0] wra, wwa;
   logic [BA_W-1:0] bra, bwa;
   logic we, be;

   state_type state_ff, state_in;
   logic [8:0] cnt_ff, cnt_in;
   logic [5:0] p_ff, p_in;
   logic [2:0] f_ff, f_in;
   logic [WIN_W-1:0] e_ff, e_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, shifted;
   logic signed [15:0] tapd_ff;
   logic signed [31:0] prod_ff;
   logic m1_ff, pv_ff;
   logic signed [15:0] res_ff, res_in;
   logic sat_ff, sat_in, last_ff, last_in, ov_ff, ov_in;
   win_ctl_type wctl;
   logic signed [15:0] tap_s;
   logic accept, live;
   logic [8:0] limit, cnt_eff, cnt_new, rel;
   logic [WIN_W-1:0] lo, widx;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !ov_ff;

   // During the MAC phase e_ff names the window cell at the multiplier. Cells
   // below lo lie outside taps_used and contribute nothing.
   assign lo = WIN_W'(WIN_LEN) - wl;
   assign live = e_ff >= lo;
   assign widx = live ? e_ff - lo : '0;

   assign wwa = WA_W'(({req_position, req_filter}) * WIN_LEN + req_tap);
   assign bwa = {req_position, req_filter};
   assign we = accept && req_opcode == OP_WEIGHT && req_tap < 4'(WIN_LEN);
   assign be = accept && req_opcode == OP_BIAS;
   assign wra = WA_W'({p_ff, f_ff}) * WA_W'(WIN_LEN) + WA_W'(widx);
   assign bra = {p_ff, f_ff};
   always_ff @(posedge clock) begin
      if (we) wmem[wwa] <= req_value;
      if (be) bmem[bwa] <= req_value;
      wrd_ff <= wmem[wra];
      brd_ff <= bmem[bra];
   end

   lc1d_window u_window (.clock, .reset, .ctl(wctl), .sample(req_value),
                         .head(WIN_W'(WIN_LEN - 1)), .tap_out(tap_s));

   assign shifted = acc_ff >>> 8;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; p_in = p_ff; f_in = f_ff; e_in = e_ff;
      acc_in = acc_ff; res_in = res_ff; sat_in = sat_ff; last_in = last_ff;
      ov_in = ov_ff && !rsp_ready;
      wctl = '0;
      limit = 9'((pu + 7'(tu) - 7'd1) * CHANNELS);
      cnt_eff = req_first ? 9'd0 : cnt_ff;
      cnt_new = cnt_eff + 9'd1;
      rel = cnt_new - 9'(wl);
      // Products are added once they have passed the operand registers and prod_ff.
      if (pv_ff) acc_in = acc_ff + ACC_W'(prod_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_SAMPLE) begin
               // A first sample clears the window as it shifts in.
               wctl.clear = req_first;
               if (cnt_eff < limit) begin
                  wctl.shift = 1'b1;
                  cnt_in = cnt_new;
                  if (cnt_new >= 9'(wl) && rel[1:0] == 2'd0 && 9'(rel >> 2) < 9'(pu)) begin
                     p_in = 6'(rel >> 2); f_in = '0; e_in = '0;
                     state_in = ST_FETCH;
                  end
               end else cnt_in = cnt_eff;
            end
         end
         ST_FETCH: begin
            // The bias read is issued here and is ready in the first MAC cycle.
            e_in = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            // The window rotates by one cell a cycle and is back in place
            // after a full turn.
            wctl.rotate = 1'b1;
            if (e_ff == '0) acc_in = ACC_W'(brd_ff) <<< 8;
            if (e_ff == WIN_W'(WIN_LEN - 1)) begin
               e_in = '0;
               state_in = ST_DONE;
            end else e_in = e_ff + 1'b1;
         end
         ST_DONE: begin
            // Once the products have drained, the accumulator holds the full sum.
            if (e_ff == WIN_W'(2)) begin
               sat_in = (shifted > ACC_W'(32767)) || (shifted < ACC_W'(-32768));
               if (shifted > ACC_W'(32767)) res_in = 16'sh7FFF;
               else if (shifted < ACC_W'(-32768)) res_in = 16'sh8000;
               else res_in = shifted[15:0];
               last_in = ({1'b0, f_ff} + 4'd1) == fu;
               ov_in = 1'b1;
               state_in = ST_OUT;
            end else e_in = e_ff + 1'b1;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (last_ff) state_in = ST_IDLE;
               else begin
                  f_in = f_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cnt_ff <= '0; ov_ff <= 1'b0; m1_ff <= 1'b0; pv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; ov_ff <= ov_in;
         m1_ff <= (state_ff == ST_MAC) && live;
         pv_ff <= m1_ff;
      end
      p_ff <= p_in; f_ff <= f_in; e_ff <= e_in; acc_ff <= acc_in;
      res_ff <= res_in; sat_ff <= sat_in; last_ff <= last_in;
      tapd_ff <= tap_s;
      prod_ff <= m1_ff ? wrd_ff * tapd_ff : 32'sd0;
   end

   assign rsp_valid = ov_ff;
   assign rsp_out_position = p_ff;
   assign rsp_out_filter = f_ff;
   assign rsp_result = res_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_last = last_ff;

   `LC_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE, "ready outside idle")
   `LC_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `LC_ASSERT_NXT(a_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_result), "result changed")
endmodule
